/* rtl/ofa_pkg.sv */
// Shared types and constants for the operand fetch addressing block.
package ofa_pkg;

   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 88;
   localparam logic [15:0] HIGH_PAGE = 16'hFF00;

   typedef enum logic [4:0] {
      AM_NONE      = 5'd0,
      AM_REG_REG8  = 5'd1,
      AM_REG_IMM8  = 5'd2,
      AM_R8_IND    = 5'd3,
      AM_IND_R8    = 5'd4,
      AM_IND_D8    = 5'd5,
      AM_IND_IND   = 5'd6,
      AM_R8_A16    = 5'd7,
      AM_A16_R8    = 5'd8,
      AM_R8_HPR    = 5'd9,
      AM_HPR_R8    = 5'd10,
      AM_R8_HPD    = 5'd11,
      AM_HPD_R8    = 5'd12,
      AM_R8_HLD    = 5'd13,
      AM_HLD_R8    = 5'd14,
      AM_R8_HLI    = 5'd15,
      AM_HLI_R8    = 5'd16,
      AM_PAIR_IMM8 = 5'd17,
      AM_R16_A16   = 5'd18,
      AM_A16_R16   = 5'd19,
      AM_PAIR_PAIR = 5'd20,
      AM_R16_SPE   = 5'd21
   } op_mode_type;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_INVALID = 2'd2
   } result_kind_type;

   localparam logic REQ_INSTR = 1'b0;
   localparam logic REQ_BYTE  = 1'b1;

   typedef struct packed {
      logic          is_byte;
      logic          invalid;
      op_mode_type   op_mode;
      logic [15:0]   first;
      logic [15:0]   second;
      logic [15:0]   pc;
      logic [7:0]    bus_byte;
   } item_type;

   typedef struct packed {
      result_kind_type kind;
      logic [15:0]     bus_address;
      logic [15:0]     fetched_value;
      logic [15:0]     dest_address;
      logic            dest_is_memory;
      logic [15:0]     next_pc;
      logic            pair_write;
      logic [15:0]     pair_value;
      logic            flags_valid;
      logic            half_carry;
      logic            carry_out;
   } result_type;

endpackage

/* rtl/operand_fetch_addressing_top.sv */
// Top level of the operand fetch addressing block.
// Operand fetch for an 8-bit CPU. Each request transfer is either a new
// instruction (tuser 0) or a byte returned by a bus read (tuser 1); every
// instruction and every byte that answers a pending read gives exactly one
// response: a bus read request, a finished fetch or an invalid-mode report.
// A byte that arrives with no read pending is dropped. One item is taken per
// cycle while the response side takes results, passing from request transfer
// to response through the front queue and then the sequencer, whose state
// update sets the rate. The queue (QUEUE_DEPTH entries) and the response
// register let either side stall without stopping the other.
module operand_fetch_addressing_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ofa_pkg::REQ_TDATA_W-1:0] req_tdata,  // op_mode, first_reg_value,
                                                       // second_reg_value, program_counter,
                                                       // bus_byte
   input  logic                            req_tuser,  // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ofa_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // bus_address, fetched_value,
                                                       // dest_address, dest_is_memory,
                                                       // next_pc, pair_write, pair_value,
                                                       // flags_valid, half_carry, carry_out
   output logic [1:0]                      rsp_tuser   // result_kind
);
   import ofa_pkg::*;

   localparam int ITEM_W = $bits(item_type);

   logic       push_valid, push_ready, pop_valid, pop_ready;
   item_type   push_item, pop_item;
   logic [ITEM_W-1:0] pop_bits;
   result_type result;

   ofa_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   ofa_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_bits)
   );

   assign pop_item = item_type'(pop_bits);

   ofa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {3'd0, result.carry_out, result.half_carry, result.flags_valid,
                       result.pair_value, result.pair_write, result.next_pc,
                       result.dest_is_memory, result.dest_address, result.fetched_value,
                       result.bus_address};

endmodule

/* rtl/ofa_front.sv */
// Front end: accepts request transfers and classifies them for the queue.
module ofa_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ofa_pkg::REQ_TDATA_W-1:0] req_tdata,  // op_mode, first, second, pc, bus_byte
   input  logic                            req_tuser,  // mode
   output logic                            push_valid,
   input  logic                            push_ready,
   output ofa_pkg::item_type               push_item
);
   import ofa_pkg::*;

   logic [4:0] raw_mode;

   assign raw_mode   = req_tdata[4:0];
   assign push_valid = req_tvalid;
   assign req_tready = push_ready;

   always_comb begin
      push_item.is_byte   = (req_tuser == REQ_BYTE);
      push_item.invalid   = (raw_mode > AM_R16_SPE);
      push_item.op_mode   = op_mode_type'(raw_mode);
      push_item.first     = req_tdata[20:5];
      push_item.second    = req_tdata[36:21];
      push_item.pc        = req_tdata[52:37];
      push_item.bus_byte  = req_tdata[60:53];
   end

endmodule

/* rtl/ofa_queue.sv */
// Small register queue between the front end and the fetch sequencer.
module ofa_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/ofa_back.sv */
// Fetch sequencer: holds the instruction context, steps through bus reads, drives results.
module ofa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  ofa_pkg::item_type pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ofa_pkg::result_type rsp_result
);
   import ofa_pkg::*;

   logic [1:0]    phase_ff, phase_in;
   op_mode_type   held_mode_ff;
   logic [15:0]   held_pc_ff, held_first_ff, held_second_ff;
   logic [7:0]    low_byte_ff, low_byte_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, res;

   logic          pop, active, is_instr;
   logic [1:0]    stage;
   op_mode_type   md;
   logic [15:0]   f, s, pc;
   logic [7:0]    b, lo;
   logic          do_req, bad, mem, pw, fv, hc, co;
   logic [15:0]   req_addr, val, dst, pv;
   logic [1:0]    pc_add;
   logic [4:0]    hsum;
   logic [8:0]    bsum;

   assign pop       = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign is_instr  = !pop_item.is_byte;
   assign active    = pop && (is_instr || phase_ff != 2'd0);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   always_comb begin
      b      = pop_item.bus_byte;
      stage  = is_instr ? 2'd0 : phase_ff;
      md     = is_instr ? pop_item.op_mode : held_mode_ff;
      f      = is_instr ? pop_item.first : held_first_ff;
      s      = is_instr ? pop_item.second : held_second_ff;
      pc     = is_instr ? pop_item.pc : held_pc_ff;
      lo     = is_instr ? 8'd0 : low_byte_ff;
      do_req = 1'b0;
      req_addr = pc;
      phase_in = 2'd0;
      low_byte_in = lo;
      bad    = is_instr && pop_item.invalid;
      val    = '0;
      dst    = '0;
      mem    = 1'b0;
      pc_add = 2'd0;
      pw     = 1'b0;
      pv     = '0;
      fv     = 1'b0;
      hsum   = {1'b0, s[3:0]} + {1'b0, b[3:0]};
      bsum   = {1'b0, s[7:0]} + {1'b0, b};
      hc     = hsum[4];
      co     = bsum[8];
      case (md) inside
         AM_NONE: ;
         AM_REG_REG8, AM_PAIR_PAIR: val = s;
         AM_IND_R8: begin
            val = s; dst = f; mem = 1'b1;
         end
         AM_HPR_R8: begin
            val = s; dst = HIGH_PAGE | {8'd0, f[7:0]}; mem = 1'b1;
         end
         AM_HLD_R8, AM_HLI_R8: begin
            val = s; dst = f; mem = 1'b1; pw = 1'b1;
            pv = (md == AM_HLD_R8) ? f - 16'd1 : f + 16'd1;
         end
         AM_REG_IMM8, AM_PAIR_IMM8: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else begin
               val = {8'd0, b}; pc_add = 2'd1;
            end
         end
         AM_IND_D8: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else begin
               val = {8'd0, b}; dst = f; mem = 1'b1; pc_add = 2'd1;
            end
         end
         AM_HPD_R8: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else begin
               val = s; dst = HIGH_PAGE | {8'd0, b}; mem = 1'b1; pc_add = 2'd1;
            end
         end
         AM_R16_SPE: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else begin
               val = s + {{8{b[7]}}, b}; pc_add = 2'd1; fv = 1'b1;
            end
         end
         AM_R8_IND, AM_IND_IND: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; req_addr = s; phase_in = 2'd1;
            end else begin
               val = {8'd0, b};
               if (md == AM_IND_IND) begin
                  dst = f; mem = 1'b1;
               end
            end
         end
         AM_R8_HLD, AM_R8_HLI: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; req_addr = s; phase_in = 2'd1;
            end else begin
               val = {8'd0, b}; pw = 1'b1;
               pv = (md == AM_R8_HLD) ? s - 16'd1 : s + 16'd1;
            end
         end
         AM_R8_HPR: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; req_addr = HIGH_PAGE | {8'd0, s[7:0]}; phase_in = 2'd1;
            end else begin
               val = {8'd0, b};
            end
         end
         AM_R8_HPD: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else if (stage == 2'd1) begin
               do_req = 1'b1; req_addr = HIGH_PAGE | {8'd0, b}; phase_in = 2'd2;
            end else begin
               val = {8'd0, b}; pc_add = 2'd1;
            end
         end
         AM_R8_A16: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else if (stage == 2'd1) begin
               low_byte_in = b; do_req = 1'b1; req_addr = pc + 16'd1; phase_in = 2'd2;
            end else if (stage == 2'd2) begin
               do_req = 1'b1; req_addr = {b, lo}; phase_in = 2'd3;
            end else begin
               val = {8'd0, b}; pc_add = 2'd2;
            end
         end
         AM_A16_R8, AM_R16_A16, AM_A16_R16: begin
            if (stage == 2'd0) begin
               do_req = 1'b1; phase_in = 2'd1;
            end else if (stage == 2'd1) begin
               low_byte_in = b; do_req = 1'b1; req_addr = pc + 16'd1; phase_in = 2'd2;
            end else if (md == AM_R16_A16) begin
               val = {b, lo}; pc_add = 2'd2;
            end else begin
               val = s; dst = {b, lo}; mem = 1'b1; pc_add = 2'd2;
            end
         end
         default: bad = 1'b1;
      endcase

      res = '0;
      if (bad) begin
         res.kind = KIND_INVALID;
         phase_in = 2'd0;
         low_byte_in = lo;
      end else if (do_req) begin
         res.kind = KIND_READ;
         res.bus_address = req_addr;
      end else begin
         res.kind           = KIND_DONE;
         res.fetched_value  = val;
         res.dest_address   = mem ? dst : 16'd0;
         res.dest_is_memory = mem;
         res.next_pc        = pc + {14'd0, pc_add};
         res.pair_write     = pw;
         res.pair_value     = pw ? pv : 16'd0;
         res.flags_valid    = fv;
         res.half_carry     = fv && hc;
         res.carry_out      = fv && co;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (active) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= 2'd0;
         held_mode_ff   <= AM_NONE;
         held_pc_ff     <= '0;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         low_byte_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (active) begin
            phase_ff    <= phase_in;
            low_byte_ff <= low_byte_in;
         end
         if (pop && is_instr) begin
            held_mode_ff   <= pop_item.op_mode;
            held_pc_ff     <= pop_item.pc;
            held_first_ff  <= pop_item.first;
            held_second_ff <= pop_item.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (active) begin
         rsp_ff <= res;
      end
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the operand fetch addressing block.
module testbench;
   import ofa_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1250;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [4:0] FIRST_INVALID_MODE = 5'd22;
   localparam logic [4:0] LAST_INVALID_MODE = 5'd31;
   localparam logic [4:0] LAST_VALID_MODE = 5'd21;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;  // op_mode, first_reg_value, second_reg_value,
                                       // program_counter, bus_byte
   logic req_tuser;                    // mode
   logic rsp_tvalid;
   logic rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;  // bus_address, fetched_value, dest_address,
                                       // dest_is_memory, next_pc, pair_write, pair_value,
                                       // flags_valid, half_carry, carry_out
   logic [1:0] rsp_tuser;              // result_kind

   operand_fetch_addressing_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // fetch sequencer copy
   logic [1:0]  fetch_phase;
   logic [4:0]  fetch_mode;
   logic [15:0] fetch_pc;
   logic [15:0] fetch_first;
   logic [15:0] fetch_second;
   logic [7:0]  fetch_low;

   result_type fetch_results_q[$];
   int error_count = 0;
   int useful_items = 0;
   int cycle_count = 0;
   int sender_gap_max = 4;
   int sink_gap_max = 4;
   logic rsp_taken = 1'b0;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   function automatic result_type read_result(input logic [15:0] addr,
                                              input logic [1:0] nxt);
      result_type r;
      r = '0;
      r.kind = KIND_READ;
      r.bus_address = addr;
      fetch_phase = nxt;
      return r;
   endfunction

   function automatic result_type done_result(input logic [15:0] value,
                                              input logic [15:0] dest,
                                              input logic mem,
                                              input logic [1:0] pc_add);
      result_type r;
      r = '0;
      r.kind = KIND_DONE;
      r.fetched_value = value;
      r.dest_address = mem ? dest : 16'h0000;
      r.dest_is_memory = mem;
      r.next_pc = fetch_pc + {14'd0, pc_add};
      fetch_phase = 2'd0;
      return r;
   endfunction

   task automatic advance_fetch(input logic [1:0] stage, input logic [7:0] b);
      result_type r;
      logic [15:0] s;
      logic [15:0] f;
      s = fetch_second;
      f = fetch_first;
      case (fetch_mode) inside
         AM_NONE: r = done_result(16'h0000, 16'h0000, 1'b0, 2'd0);
         AM_REG_REG8, AM_PAIR_PAIR: r = done_result(s, 16'h0000, 1'b0, 2'd0);
         AM_IND_R8: r = done_result(s, f, 1'b1, 2'd0);
         AM_HPR_R8: r = done_result(s, HIGH_PAGE | {8'h00, f[7:0]}, 1'b1, 2'd0);
         AM_HLD_R8, AM_HLI_R8: begin
            r = done_result(s, f, 1'b1, 2'd0);
            r.pair_write = 1'b1;
            r.pair_value = (fetch_mode == AM_HLD_R8) ? f - 16'd1 : f + 16'd1;
         end
         AM_REG_IMM8, AM_PAIR_IMM8: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd1);
         end
         AM_IND_D8: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else r = done_result({8'h00, b}, f, 1'b1, 2'd1);
         end
         AM_HPD_R8: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else r = done_result(s, HIGH_PAGE | {8'h00, b}, 1'b1, 2'd1);
         end
         AM_R16_SPE: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else begin
               r = done_result(s + {{8{b[7]}}, b}, 16'h0000, 1'b0, 2'd1);
               r.flags_valid = 1'b1;
               r.half_carry = ({1'b0, s[3:0]} + {1'b0, b[3:0]}) > 5'd15;
               r.carry_out = ({1'b0, s[7:0]} + {1'b0, b}) > 9'd255;
            end
         end
         AM_R8_IND: begin
            if (stage == 2'd0) r = read_result(s, 2'd1);
            else r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd0);
         end
         AM_IND_IND: begin
            if (stage == 2'd0) r = read_result(s, 2'd1);
            else r = done_result({8'h00, b}, f, 1'b1, 2'd0);
         end
         AM_R8_HLD, AM_R8_HLI: begin
            if (stage == 2'd0) r = read_result(s, 2'd1);
            else begin
               r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd0);
               r.pair_write = 1'b1;
               r.pair_value = (fetch_mode == AM_R8_HLD) ? s - 16'd1 : s + 16'd1;
            end
         end
         AM_R8_HPR: begin
            if (stage == 2'd0) r = read_result(HIGH_PAGE | {8'h00, s[7:0]}, 2'd1);
            else r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd0);
         end
         AM_R8_HPD: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else if (stage == 2'd1) r = read_result(HIGH_PAGE | {8'h00, b}, 2'd2);
            else r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd1);
         end
         AM_R8_A16: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else if (stage == 2'd1) begin
               fetch_low = b;
               r = read_result(fetch_pc + 16'd1, 2'd2);
            end else if (stage == 2'd2) r = read_result({b, fetch_low}, 2'd3);
            else r = done_result({8'h00, b}, 16'h0000, 1'b0, 2'd2);
         end
         AM_A16_R8, AM_R16_A16, AM_A16_R16: begin
            if (stage == 2'd0) r = read_result(fetch_pc, 2'd1);
            else if (stage == 2'd1) begin
               fetch_low = b;
               r = read_result(fetch_pc + 16'd1, 2'd2);
            end else if (fetch_mode == AM_R16_A16)
               r = done_result({b, fetch_low}, 16'h0000, 1'b0, 2'd2);
            else r = done_result(s, {b, fetch_low}, 1'b1, 2'd2);
         end
         default: begin
            r = '0;
            r.kind = KIND_INVALID;
            fetch_phase = 2'd0;
         end
      endcase
      fetch_results_q.push_back(r);
   endtask

   task automatic predict_fetch(input logic is_byte, input logic [4:0] am,
                                input logic [15:0] f, input logic [15:0] s,
                                input logic [15:0] pc, input logic [7:0] b);
      if (is_byte == REQ_INSTR) begin
         fetch_mode = am;
         fetch_first = f;
         fetch_second = s;
         fetch_pc = pc;
         fetch_low = 8'h00;
         fetch_phase = 2'd0;
         advance_fetch(2'd0, 8'h00);
      end else if (fetch_phase != 2'd0) begin
         advance_fetch(fetch_phase, b);
      end
   endtask

   // Called right after a rising edge; returns right after the accepting edge.
   task automatic send_item(input logic is_byte, input logic [4:0] am,
                            input logic [15:0] f, input logic [15:0] s,
                            input logic [15:0] pc, input logic [7:0] b);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= is_byte;
      req_tdata <= {3'b000, b, pc, s, f, am};
      do @(negedge clock); while (!req_tready);
      if (!(is_byte == REQ_BYTE && fetch_phase == 2'd0)) useful_items++;
      predict_fetch(is_byte, am, f, s, pc, b);
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic send_instr(input logic [4:0] am, input logic [15:0] f,
                             input logic [15:0] s, input logic [15:0] pc);
      send_item(REQ_INSTR, am, f, s, pc, pick_byte());
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_item(REQ_BYTE, 5'($urandom), pick_word(), pick_word(), pick_word(), b);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (fetch_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_register_modes();
      send_instr(AM_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_instr(AM_REG_REG8, 16'h1234, 16'h00FF, 16'h0000);
      send_instr(AM_IND_R8, 16'hFFFF, 16'h5A5A, 16'h8000);
      send_instr(AM_HPR_R8, 16'h12CD, 16'h00FF, 16'h0001);
      send_instr(AM_HLD_R8, 16'h0000, 16'h0042, 16'h1000);
      send_instr(AM_HLI_R8, 16'hFFFF, 16'h0099, 16'h2000);
      send_instr(AM_PAIR_PAIR, 16'h0000, 16'hFFFF, 16'hFFFF);
      drain_results();
   endtask

   task automatic test_immediate_modes();
      send_instr(AM_REG_IMM8, 16'h0000, 16'h0000, 16'hFFFF);
      send_byte(8'hFF);
      send_instr(AM_PAIR_IMM8, 16'hFFFF, 16'hFFFF, 16'h0100);
      send_byte(8'h80);
      send_instr(AM_IND_D8, 16'hC000, 16'h1111, 16'h7FFF);
      send_byte(8'h00);
      send_instr(AM_HPD_R8, 16'h2222, 16'h00AA, 16'h4000);
      send_byte(8'hFF);
      send_instr(AM_R16_SPE, 16'h0000, 16'hFFFF, 16'h0200);
      send_byte(8'h01);
      send_instr(AM_R16_SPE, 16'h0000, 16'h0008, 16'hFFFF);
      send_byte(8'h88);
      drain_results();
   endtask

   task automatic test_pointer_modes();
      send_instr(AM_R8_IND, 16'h0000, 16'hFFFF, 16'h0300);
      send_byte(8'h5A);
      send_instr(AM_IND_IND, 16'hA000, 16'h8001, 16'h0301);
      send_byte(8'hA5);
      send_instr(AM_R8_HLD, 16'h0000, 16'h0000, 16'h0302);
      send_byte(8'h01);
      send_instr(AM_R8_HLI, 16'h0000, 16'hFFFF, 16'h0303);
      send_byte(8'hFE);
      send_instr(AM_R8_HPR, 16'h0000, 16'h12FF, 16'h0304);
      send_byte(8'h7F);
      send_instr(AM_R8_HPD, 16'h0000, 16'h0000, 16'hFFFF);
      send_byte(8'h80);
      send_byte(8'h3C);
      drain_results();
   endtask

   task automatic test_absolute_modes();
      send_instr(AM_R8_A16, 16'h0000, 16'h0000, 16'hFFFF);
      send_byte(8'h34);
      send_byte(8'h12);
      send_byte(8'hC3);
      send_instr(AM_A16_R8, 16'h0000, 16'h00EE, 16'h0400);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_instr(AM_R16_A16, 16'h0000, 16'h0000, 16'hFFFE);
      send_byte(8'h00);
      send_byte(8'h80);
      send_instr(AM_A16_R16, 16'h0000, 16'hBEEF, 16'h0500);
      send_byte(8'h01);
      send_byte(8'h00);
      drain_results();
   endtask

   task automatic test_invalid_and_stray();
      send_byte(8'h55);
      send_instr(FIRST_INVALID_MODE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_instr(LAST_INVALID_MODE, 16'h0000, 16'h0000, 16'h0000);
      send_instr(AM_R8_A16, 16'h0000, 16'h0000, 16'h0600);
      send_byte(8'h11);
      send_instr(AM_REG_REG8, 16'h0000, 16'h0077, 16'h0700);
      send_byte(8'hAA);
      drain_results();
   endtask

   task automatic test_random_sequences();
      int r;
      logic [4:0] am;
      while (useful_items < RANDOM_ITEMS) begin
         if (useful_items > 300 && useful_items < 450) begin
            sender_gap_max = 0;
            sink_gap_max = 0;
         end else begin
            sender_gap_max = 4;
            sink_gap_max = 4;
         end
         if ($urandom_range(0, 99) == 0) drain_results();
         r = $urandom_range(0, 99);
         if (r < 4) begin
            send_byte(pick_byte());
         end else begin
            if (r < 12) am = 5'($urandom_range(FIRST_INVALID_MODE, LAST_INVALID_MODE));
            else am = 5'($urandom_range(0, LAST_VALID_MODE));
            send_instr(am, pick_word(), pick_word(), pick_word());
            while (fetch_phase != 2'd0) begin
               if ($urandom_range(0, 99) < 4) break;
               send_byte(pick_byte());
            end
         end
      end
      drain_results();
   endtask

   // result sink: stall a random number of cycles before each transfer
   initial begin
      int gap;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = $urandom_range(0, sink_gap_max);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_taken);
      end
   end

   always @(negedge clock) begin
      result_type want;
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (rsp_taken) begin
         if (fetch_results_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result, kind %0d", rsp_tuser));
         end else begin
            want = fetch_results_q.pop_front();
            check_field("result_kind", 16'(rsp_tuser), 16'(want.kind));
            check_field("bus_address", rsp_tdata[15:0], want.bus_address);
            check_field("fetched_value", rsp_tdata[31:16], want.fetched_value);
            check_field("dest_address", rsp_tdata[47:32], want.dest_address);
            check_field("dest_is_memory", 16'(rsp_tdata[48]), 16'(want.dest_is_memory));
            check_field("next_pc", rsp_tdata[64:49], want.next_pc);
            check_field("pair_write", 16'(rsp_tdata[65]), 16'(want.pair_write));
            check_field("pair_value", rsp_tdata[81:66], want.pair_value);
            check_field("flags_valid", 16'(rsp_tdata[82]), 16'(want.flags_valid));
            check_field("half_carry", 16'(rsp_tdata[83]), 16'(want.half_carry));
            check_field("carry_out", 16'(rsp_tdata[84]), 16'(want.carry_out));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = REQ_INSTR;
      req_tdata = '0;
      fetch_phase = 2'd0;
      fetch_mode = 5'd0;
      fetch_pc = 16'h0000;
      fetch_first = 16'h0000;
      fetch_second = 16'h0000;
      fetch_low = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_register_modes();
      test_immediate_modes();
      test_pointer_modes();
      test_absolute_modes();
      test_invalid_and_stray();
      test_random_sequences();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fetch_results_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", fetch_results_q.size()));
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

/* operand_fetch_addressing_top.f */
rtl/ofa_pkg.sv
rtl/ofa_front.sv
rtl/ofa_queue.sv
rtl/ofa_back.sv
rtl/operand_fetch_addressing_top.sv
verif/testbench.sv
